// File: hdl/pbpt_pkg.sv
// ----------------------------------------------------------------------------
// pbpt_pkg
// Types, register indexes and constants shared by the Poincare ball transport
// block, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package pbpt_pkg;

  // Q4.12 element as carried on the channels
  typedef logic signed [15:0] elem_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CURVATURE = 2'd0;
  localparam cfg_idx_t CFG_MIN_DENOM = 2'd1;
  localparam cfg_idx_t CFG_MODE      = 2'd2;

  // transport modes
  localparam logic [1:0] MODE_TO_ORIGIN   = 2'd0;
  localparam logic [1:0] MODE_FROM_ORIGIN = 2'd1;
  localparam logic [1:0] MODE_P_TO_Q      = 2'd2;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  // register reset values
  localparam logic [15:0] CURVATURE_RST = 16'd4096;
  localparam logic [15:0] MIN_DENOM_RST = 16'd66;
  localparam logic [1:0]  MODE_RST      = MODE_P_TO_Q;

  // widths and fixed constants
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned DEN_W     = 17;
  localparam int unsigned QUOT_W    = 33;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [SCALE_W-1:0]   SCALE_ONE = 32'h0001_0000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd32;

  localparam logic signed [15:0] ELEM_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ELEM_MIN = 16'sh8000;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SQP   = 11'b000_0000_0010,
    ST_SQQ   = 11'b000_0000_0100,
    ST_ACCQ  = 11'b000_0000_1000,
    ST_PLO   = 11'b000_0001_0000,
    ST_PHI   = 11'b000_0010_0000,
    ST_DEN   = 11'b000_0100_0000,
    ST_SCALE = 11'b000_1000_0000,
    ST_DIV   = 11'b001_0000_0000,
    ST_VMUL  = 11'b010_0000_0000,
    ST_VOUT  = 11'b100_0000_0000
  } state_t;

endpackage

// File: hdl/pbpt_in_if.sv
// ----------------------------------------------------------------------------
// pbpt_in_if
// Input channel: load items (point elements) and vector items.
// ----------------------------------------------------------------------------
interface pbpt_in_if;
  import pbpt_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  elem_t p_elem;
  elem_t q_elem;
  elem_t v_elem;
  logic  last;

  modport source (output valid, output kind, output p_elem, output q_elem,
                  output v_elem, output last, input ready);
  modport sink   (input valid, input kind, input p_elem, input q_elem,
                  input v_elem, input last, output ready);
endinterface

// File: hdl/pbpt_out_if.sv
// ----------------------------------------------------------------------------
// pbpt_out_if
// Result channel: transported vector elements.
// ----------------------------------------------------------------------------
interface pbpt_out_if;
  import pbpt_pkg::*;

  logic  valid;
  logic  ready;
  elem_t out_elem;
  logic  out_last;
  logic  saturated;

  modport source (output valid, output out_elem, output out_last,
                  output saturated, input ready);
  modport sink   (input valid, input out_elem, input out_last,
                  input saturated, output ready);
endinterface

// File: hdl/poincare_ball_parallel_transport.sv
// ----------------------------------------------------------------------------
// poincare_ball_parallel_transport
// Conformal-scale parallel transport on the Poincare ball, built around one
// shared 32x32 multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | transfer / write       | payload
//  in_if   | in  | valid & ready          | kind, p_elem, q_elem, v_elem, last
//  out_if  | out | valid & ready          | out_elem, out_last, saturated
//  cfg_*   | in  | cfg_we (no handshake)  | cfg_index, cfg_wdata
//
//  Load item: accept, square p, square q, accumulate. For c > 0, modes 0-2,
//  the last load item adds two denominators, set-up and (not from origin) the
//  divider. Vector item: accept, multiply, round while the output is free.
//  in_if.ready is high only in the idle state; a finished result waits in the
//  output register, and a vector item stalls there until that register frees.
//  Reset is synchronous: registers at their reset values, output empty.
// ----------------------------------------------------------------------------
module poincare_ball_parallel_transport (
  input  logic                clk,
  input  logic                rst_n,
  pbpt_in_if.sink             in_if,
  pbpt_out_if.source          out_if,
  input  logic                cfg_we,
  input  pbpt_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import pbpt_pkg::*;

  // control state
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           curvature_r, curvature_nxt;
  logic [15:0]           min_denom_r, min_denom_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [ACC_W-1:0]      acc_p_r, acc_p_nxt;
  logic [ACC_W-1:0]      acc_q_r, acc_q_nxt;
  logic [SCALE_W-1:0]    scale_r, scale_nxt;
  logic                  sel_q_r, sel_q_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  // datapath
  logic [15:0]           p_mag_r, q_mag_r, v_mag_r;
  logic                  v_neg_r, last_r;
  logic [63:0]           mul_r;
  logic [46:0]           lo_r;
  logic [DEN_W-1:0]      dp_r, dq_r;
  logic [QUOT_W-1:0]     num_r;
  logic [15:0]           rem_r;
  elem_t                 out_elem_r;
  logic                  out_last_r, sat_r;

  logic                  in_xfer, out_free, c_pos;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic [ACC_W-1:0]      acc_sel;
  logic [ACC_W:0]        sum_p, sum_q;
  logic [62:0]           prod;
  logic [36:0]           diff;
  logic [DEN_W-1:0]      d_raw, d_lo, d_val;
  logic [16:0]           rem_sh;
  logic                  q_bit;
  logic [16:0]           rem_sub;
  logic [QUOT_W-1:0]     quot;
  logic [47:0]           rnd;
  logic [31:0]           r_mag;
  elem_t                 res_elem;
  logic                  res_sat;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    mag16 = x[15] ? (~x + 16'd1) : x;
  endfunction

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign c_pos    = !curvature_r[15] && (curvature_r[14:0] != 15'd0);
  assign acc_sel  = sel_q_r ? acc_q_r : acc_p_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQP: begin
        mul_a = {16'd0, p_mag_r};
        mul_b = {16'd0, p_mag_r};
      end
      ST_SQQ: begin
        mul_a = {16'd0, q_mag_r};
        mul_b = {16'd0, q_mag_r};
      end
      ST_PLO: begin
        mul_a = {17'd0, curvature_r[14:0]};
        mul_b = acc_sel[31:0];
      end
      ST_PHI: begin
        mul_a = {17'd0, curvature_r[14:0]};
        mul_b = {16'd0, acc_sel[47:32]};
      end
      ST_VMUL: begin
        mul_a = {16'd0, v_mag_r};
        mul_b = scale_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // saturating accumulation of squares
  assign sum_p = {1'b0, acc_p_r} + {18'd0, mul_r[30:0]};
  assign sum_q = {1'b0, acc_q_r} + {18'd0, mul_r[30:0]};

  // clamped denominator: max(1 - c*|x|^2, min_denom) in Q0.16
  assign prod  = {mul_r[30:0], 32'd0} + {16'd0, lo_r};
  assign diff  = {1'b1, 36'd0} - {1'b0, prod[35:0]};
  assign d_raw = (prod[62:36] == 27'd0) ? diff[36:20] : '0;
  assign d_lo  = (min_denom_r == 16'd0) ? 17'd1 : {1'b0, min_denom_r};
  assign d_val = (d_raw < d_lo) ? d_lo : d_raw;

  // one restoring divider step, quotient shifts into num_r
  assign rem_sh  = {rem_r, num_r[QUOT_W-1]};
  assign q_bit   = (rem_sh >= dp_r);
  assign rem_sub = q_bit ? (rem_sh - dp_r) : rem_sh;
  assign quot    = {num_r[QUOT_W-2:0], q_bit};

  // round to nearest (ties away) and saturate the scaled magnitude
  assign rnd   = mul_r[47:0] + 48'h8000;
  assign r_mag = rnd[47:16];
  always_comb begin
    if (v_neg_r) begin
      res_sat  = (r_mag > 32'd32768);
      res_elem = res_sat ? ELEM_MIN : elem_t'(~r_mag[15:0] + 16'd1);
    end else begin
      res_sat  = (r_mag > 32'd32767);
      res_elem = res_sat ? ELEM_MAX : elem_t'(r_mag[15:0]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    curvature_nxt = curvature_r;
    min_denom_nxt = min_denom_r;
    mode_nxt      = mode_r;
    acc_p_nxt     = acc_p_r;
    acc_q_nxt     = acc_q_r;
    scale_nxt     = scale_r;
    sel_q_nxt     = sel_q_r;
    cnt_nxt       = cnt_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_CURVATURE: curvature_nxt = cfg_wdata;
        CFG_MIN_DENOM: min_denom_nxt = cfg_wdata;
        CFG_MODE:      mode_nxt      = cfg_wdata[1:0];
        default:       ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_if.kind == KIND_VECTOR) ? ST_VMUL : ST_SQP;
        end
      end
      ST_SQP: state_nxt = ST_SQQ;
      ST_SQQ: begin
        acc_p_nxt = sum_p[ACC_W] ? '1 : sum_p[ACC_W-1:0];
        state_nxt = ST_ACCQ;
      end
      ST_ACCQ: begin
        acc_q_nxt = sum_q[ACC_W] ? '1 : sum_q[ACC_W-1:0];
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!c_pos || mode_r > MODE_P_TO_Q) begin
          scale_nxt = SCALE_ONE;
          acc_p_nxt = '0;
          acc_q_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sel_q_nxt = 1'b0;
          state_nxt = ST_PLO;
        end
      end
      ST_PLO: state_nxt = ST_PHI;
      ST_PHI: state_nxt = ST_DEN;
      ST_DEN: begin
        if (!sel_q_r) begin
          sel_q_nxt = 1'b1;
          state_nxt = ST_PLO;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cnt_nxt = '0;
        if (mode_r == MODE_FROM_ORIGIN) begin
          scale_nxt = {15'd0, dp_r};
          acc_p_nxt = '0;
          acc_q_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          scale_nxt = quot[QUOT_W-1] ? '1 : quot[SCALE_W-1:0];
          acc_p_nxt = '0;
          acc_q_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_VMUL: state_nxt = ST_VOUT;
      ST_VOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      curvature_r <= CURVATURE_RST;
      min_denom_r <= MIN_DENOM_RST;
      mode_r      <= MODE_RST;
      acc_p_r     <= '0;
      acc_q_r     <= '0;
      scale_r     <= SCALE_ONE;
      sel_q_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      curvature_r <= curvature_nxt;
      min_denom_r <= min_denom_nxt;
      mode_r      <= mode_nxt;
      acc_p_r     <= acc_p_nxt;
      acc_q_r     <= acc_q_nxt;
      scale_r     <= scale_nxt;
      sel_q_r     <= sel_q_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_mag_r <= mag16(in_if.p_elem);
      q_mag_r <= mag16(in_if.q_elem);
      v_mag_r <= mag16(in_if.v_elem);
      v_neg_r <= in_if.v_elem[15];
      last_r  <= in_if.last;
    end
    if (state_r == ST_SQP || state_r == ST_SQQ || state_r == ST_PLO ||
        state_r == ST_PHI || state_r == ST_VMUL) begin
      mul_r <= mul_p;
    end
    if (state_r == ST_PHI) begin
      lo_r <= mul_r[46:0];
    end
    if (state_r == ST_DEN) begin
      if (sel_q_r) begin
        dq_r <= d_val;
      end else begin
        dp_r <= d_val;
      end
    end
    if (state_r == ST_SCALE) begin
      num_r <= (mode_r == MODE_TO_ORIGIN) ? {1'b1, 32'd0} : {dq_r, 16'd0};
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      num_r <= quot;
      rem_r <= rem_sub[15:0];
    end
    if (state_r == ST_VOUT && out_free) begin
      out_elem_r <= res_elem;
      out_last_r <= last_r;
      sat_r      <= res_sat;
    end
  end

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.out_elem  = out_elem_r;
  assign out_if.out_last  = out_last_r;
  assign out_if.saturated = sat_r;

endmodule

// File: hdl/pbpt_checker.sv
// ----------------------------------------------------------------------------
// pbpt_checker
// Port-level checks on the transport block, bound to the top level.
// ----------------------------------------------------------------------------
module pbpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_elem,
  input logic               out_last,
  input logic               saturated
);
  import pbpt_pkg::*;

  // empty output and ready input straight after reset
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty or input not ready after reset");

  // the sequencer is busy in the cycle after any transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after a transfer");

  // a load item never yields a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_LOAD && !out_valid |=> !out_valid)
    else $error("result raised by a load item");

  // a clipped result sits at one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> out_elem == ELEM_MAX || out_elem == ELEM_MIN)
    else $error("saturated flag on an unclipped element");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_elem) &&
      $stable(out_last) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind poincare_ball_parallel_transport pbpt_checker u_pbpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_kind   (in_if.kind),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_elem  (out_if.out_elem),
  .out_last  (out_if.out_last),
  .saturated (out_if.saturated)
);

// File: dv/tb_poincare_ball_parallel_transport.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_poincare_ball_parallel_transport
// Self-checking bench for the Poincare ball transport block. Points are
// streamed as load items and tangent vectors as vector items. An in-bench
// model of the norms, the clamped denominators and the scale predicts every
// transported element, which is compared field by field as it leaves.
// Directed cases come first, then random traffic over several register
// settings, with bursty input and a stalling result channel.
// ----------------------------------------------------------------------------
module tb_poincare_ball_parallel_transport;
  import pbpt_pkg::*;

  localparam int unsigned  SETTLE_CYCLES  = 60;    // outlasts the longest item, a last load item
  localparam int unsigned  WATCHDOG_LIMIT = 4000;
  localparam int unsigned  PHASE_ITEMS    = 92;
  localparam int unsigned  N_PHASES       = 8;
  localparam logic [1:0]   MODE_UNUSED    = 2'd3;
  localparam logic [63:0]  ONE_Q36        = 64'd1 << 36;
  localparam logic [47:0]  NORM_MAX       = {48{1'b1}};

  typedef struct packed {
    logic  kind;
    elem_t p;
    elem_t q;
    elem_t v;
    logic  last;
  } pbpt_item_t;

  typedef struct packed {
    elem_t elem;
    logic  last;
    logic  sat;
  } vec_result_t;

  logic clk;
  logic rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [15:0] cfg_wdata;

  pbpt_in_if  in_if ();
  pbpt_out_if out_if ();

  poincare_ball_parallel_transport u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state and register copies
  logic [15:0] curv_r;
  logic [15:0] min_denom_r;
  logic [1:0]  mode_r;
  logic [47:0] norm_p;
  logic [47:0] norm_q;
  logic [31:0] scale_r;

  vec_result_t transported_q[$];

  int unsigned n_errors;
  int unsigned n_loads;
  int unsigned n_points;
  int unsigned n_vectors;
  int unsigned n_checked;
  int unsigned n_sat_seen;
  int unsigned n_settings;
  int unsigned burst_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // transport model
  // --------------------------------------------------------------------------

  // sum of squares, saturating at the accumulator width
  function automatic logic [47:0] add_square(logic [47:0] acc, elem_t x);
    logic signed [63:0] xw;
    logic [63:0] s;
    xw = x;
    s = {16'd0, acc} + 64'(xw * xw);
    add_square = (s > {16'd0, NORM_MAX}) ? NORM_MAX : s[47:0];
  endfunction

  // d = max(floor(1 - c*|x|^2) in Q0.16, lo)
  function automatic logic [16:0] conformal_denom(logic [47:0] acc, logic [14:0] c,
                                                  logic [16:0] lo);
    logic [63:0] prod;
    logic [16:0] d;
    prod = {49'd0, c} * {16'd0, acc};
    d = '0;
    if (prod < ONE_Q36) d = 17'((ONE_Q36 - prod) >> 20);
    if (d < lo) d = lo;
    conformal_denom = d;
  endfunction

  function automatic logic [31:0] sat_scale(logic [63:0] v);
    sat_scale = (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // scale formed at the end of a point
  function automatic void derive_scale();
    logic signed [15:0] c;
    logic [16:0] lo;
    logic [16:0] dp;
    logic [16:0] dq;
    c  = curv_r;
    lo = (min_denom_r == 16'd0) ? 17'd1 : {1'b0, min_denom_r};
    if (c <= 0 || mode_r > MODE_P_TO_Q) begin
      scale_r = SCALE_ONE;
    end else begin
      dp = conformal_denom(norm_p, c[14:0], lo);
      dq = conformal_denom(norm_q, c[14:0], lo);
      case (mode_r)
        MODE_TO_ORIGIN:   scale_r = sat_scale((64'd1 << 32) / {47'd0, dp});
        MODE_FROM_ORIGIN: scale_r = {15'd0, dp};
        default:          scale_r = sat_scale(({47'd0, dq} << 16) / {47'd0, dp});
      endcase
    end
  endfunction

  // v * scale, rounded half away from zero to Q4.12, then clipped
  function automatic vec_result_t transport_elem(elem_t v, logic last);
    logic signed [16:0] vw;
    logic [16:0] absv;
    logic [63:0] mag;
    logic [63:0] r;
    vec_result_t e;
    vw   = v;
    absv = (vw < 0) ? 17'(-vw) : 17'(vw);
    mag  = {47'd0, absv} * {32'd0, scale_r};
    r    = (mag + 64'h8000) >> 16;
    e.sat  = 1'b0;
    e.last = last;
    if (vw < 0) begin
      if (r > 64'd32768) begin
        r = 64'd32768;
        e.sat = 1'b1;
      end
      e.elem = 16'(64'd0 - r);
    end else begin
      if (r > 64'd32767) begin
        r = 64'd32767;
        e.sat = 1'b1;
      end
      e.elem = 16'(r);
    end
    transport_elem = e;
  endfunction

  // apply one accepted item to the model
  task automatic absorb_item(pbpt_item_t it);
    if (it.kind == KIND_LOAD) begin
      norm_p = add_square(norm_p, it.p);
      norm_q = add_square(norm_q, it.q);
      n_loads++;
      if (it.last) begin
        derive_scale();
        norm_p = '0;
        norm_q = '0;
        n_points++;
      end
    end else begin
      transported_q.push_back(transport_elem(it.v, it.last));
      n_vectors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic pbpt_item_t make_item(logic kind, elem_t p, elem_t q, elem_t v,
                                           logic last);
    pbpt_item_t it;
    it.kind = kind;
    it.p    = p;
    it.q    = q;
    it.v    = v;
    it.last = last;
    make_item = it;
  endfunction

  // mostly small magnitudes so points land inside the ball
  function automatic elem_t rand_elem();
    int unsigned k;
    logic [15:0] m;
    case ($urandom_range(0, 9))
      0: rand_elem = 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       rand_elem = ELEM_MAX;
          1:       rand_elem = ELEM_MIN;
          2:       rand_elem = 16'sd0;
          default: rand_elem = -16'sd1;
        endcase
      end
      default: begin
        k = $urandom_range(4, 12);
        m = 16'($urandom_range(0, (1 << k) - 1));
        rand_elem = $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  function automatic int unsigned rand_len();
    rand_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
  endfunction

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 50) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 15);
    end
  endtask

  // present one item and hold it until the transfer
  task automatic send_item(pbpt_item_t it);
    in_if.valid  <= 1'b1;
    in_if.kind   <= it.kind;
    in_if.p_elem <= it.p;
    in_if.q_elem <= it.q;
    in_if.v_elem <= it.v;
    in_if.last   <= it.last;
    do @(posedge clk); while (!in_if.ready);
    absorb_item(it);
    pace();
  endtask

  // wait for every result, then for the block to finish any point work
  task automatic drain();
    in_if.valid <= 1'b0;
    while (transported_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CURVATURE: curv_r      = val;
      CFG_MIN_DENOM: min_denom_r = val;
      CFG_MODE:      mode_r      = val[1:0];
      default: ;
    endcase
  endtask

  task automatic send_point(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(make_item(KIND_LOAD, rand_elem(), rand_elem(), 16'($urandom), i == n - 1));
  endtask

  task automatic send_vector(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(make_item(KIND_VECTOR, 16'($urandom), 16'($urandom), rand_elem(),
                          i == n - 1));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // vectors before any point use the reset scale of 1.0
  task automatic test_vector_before_point();
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, ELEM_MAX, 1'b0));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, ELEM_MIN, 1'b0));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, 16'sd0, 1'b0));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, -16'sd1, 1'b1));
  endtask

  // one two-element point and a vector under each transport mode
  task automatic test_mode_scales();
    logic [1:0] modes [3];
    modes = '{MODE_TO_ORIGIN, MODE_FROM_ORIGIN, MODE_P_TO_Q};
    foreach (modes[i]) begin
      write_reg(CFG_MODE, {14'd0, modes[i]});
      send_item(make_item(KIND_LOAD, 16'sh0800, 16'sh0400, 16'sd0, 1'b0));
      send_item(make_item(KIND_LOAD, -16'sh0800, 16'sd0, 16'sd0, 1'b1));
      send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, 16'sh1234, 1'b1));
    end
  endtask

  // zero and negative curvature give identity transport
  task automatic test_nonpositive_curvature();
    write_reg(CFG_CURVATURE, 16'd0);
    send_item(make_item(KIND_LOAD, 16'sh0600, 16'sh0100, 16'sd0, 1'b1));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, 16'sh4321, 1'b1));
    write_reg(CFG_CURVATURE, 16'h8000);
    send_item(make_item(KIND_LOAD, 16'sh0300, -16'sh0700, 16'sd0, 1'b1));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, -16'sh2222, 1'b1));
  endtask

  // zero clamp acts as one, so 1/d overflows the scale; outputs clip
  task automatic test_scale_saturation();
    write_reg(CFG_MIN_DENOM, 16'd0);
    write_reg(CFG_CURVATURE, 16'h7FFF);
    write_reg(CFG_MODE, {14'd0, MODE_TO_ORIGIN});
    send_item(make_item(KIND_LOAD, ELEM_MAX, ELEM_MIN, ELEM_MAX, 1'b1));
    send_item(make_item(KIND_VECTOR, ELEM_MIN, ELEM_MAX, 16'sd1, 1'b0));
    send_item(make_item(KIND_VECTOR, ELEM_MAX, ELEM_MIN, ELEM_MIN, 1'b1));
  endtask

  // mode 3 falls back to identity
  task automatic test_unused_mode();
    write_reg(CFG_CURVATURE, 16'd4096);
    write_reg(CFG_MODE, {14'd0, MODE_UNUSED});
    send_item(make_item(KIND_LOAD, 16'sh0200, 16'sh0900, 16'sd0, 1'b1));
    send_item(make_item(KIND_VECTOR, 16'sd0, 16'sd0, 16'sh7000, 1'b1));
  endtask

  // random points and vectors over a range of register settings
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_CURVATURE, CURVATURE_RST);
          write_reg(CFG_MIN_DENOM, MIN_DENOM_RST);
          write_reg(CFG_MODE, {14'd0, MODE_RST});
        end
        1: begin
          write_reg(CFG_CURVATURE, 16'h7FFF);
          write_reg(CFG_MIN_DENOM, 16'd1);
          write_reg(CFG_MODE, {14'd0, MODE_TO_ORIGIN});
        end
        2: begin
          write_reg(CFG_CURVATURE, 16'd1);
          write_reg(CFG_MIN_DENOM, 16'hFFFF);
          write_reg(CFG_MODE, {14'd0, MODE_FROM_ORIGIN});
        end
        3: begin
          write_reg(CFG_CURVATURE, 16'h8000);
          write_reg(CFG_MIN_DENOM, 16'($urandom));
          write_reg(CFG_MODE, {14'd0, MODE_P_TO_Q});
        end
        4: begin
          write_reg(CFG_CURVATURE, 16'($urandom_range(1, 32767)));
          write_reg(CFG_MIN_DENOM, 16'($urandom_range(1, 4096)));
          write_reg(CFG_MODE, {14'd0, MODE_P_TO_Q});
        end
        5: begin
          write_reg(CFG_CURVATURE, 16'($urandom));
          write_reg(CFG_MIN_DENOM, 16'($urandom));
          write_reg(CFG_MODE, 16'($urandom_range(0, 3)));
        end
        6: begin
          write_reg(CFG_CURVATURE, 16'd2048);
          write_reg(CFG_MIN_DENOM, 16'd1000);
          write_reg(CFG_MODE, {14'd0, MODE_TO_ORIGIN});
        end
        default: begin
          write_reg(CFG_CURVATURE, 16'd4096);
          write_reg(CFG_MIN_DENOM, 16'd66);
          write_reg(CFG_MODE, {14'd0, MODE_FROM_ORIGIN});
        end
      endcase
      n_settings++;
      target = n_loads + n_vectors + PHASE_ITEMS;
      while (n_loads + n_vectors < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // well-formed point followed by a vector
          send_point(rand_len());
          send_vector(rand_len());
        end else if (pick == 8) begin
          // noise: kind and last at random, so points run on or break off
          repeat ($urandom_range(1, 6))
            send_item(make_item(1'($urandom_range(0, 1)), rand_elem(), rand_elem(),
                                rand_elem(), 1'($urandom_range(0, 1))));
        end else begin
          // vector reusing the previous scale
          send_vector(rand_len());
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result checker with its own stall pattern
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  initial begin
    int unsigned seg_left;
    int unsigned seg_style;
    int unsigned seg_phase;
    vec_result_t want;
    out_if.ready <= 1'b0;
    seg_left  = 0;
    seg_style = 0;
    seg_phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (transported_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected (elem %h)",
                                    n_checked, out_if.out_elem));
        end else begin
          want = transported_q.pop_front();
          if (out_if.out_elem !== want.elem)
            report_mismatch($sformatf("result %0d out_elem %h, expected %h",
                                      n_checked, out_if.out_elem, want.elem));
          if (out_if.out_last !== want.last)
            report_mismatch($sformatf("result %0d out_last %b, expected %b",
                                      n_checked, out_if.out_last, want.last));
          if (out_if.saturated !== want.sat)
            report_mismatch($sformatf("result %0d saturated %b, expected %b",
                                      n_checked, out_if.saturated, want.sat));
          if (want.sat) n_sat_seen++;
        end
        n_checked++;
      end
      // next ready from the stall pattern
      if (seg_left == 0) begin
        seg_style = $urandom_range(0, 3);
        seg_left  = $urandom_range(8, 96);
      end
      seg_left--;
      seg_phase++;
      case (seg_style)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (seg_phase % 8 >= 5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles without any transfer or register write
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_CURVATURE;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_LOAD;
    in_if.p_elem <= '0;
    in_if.q_elem <= '0;
    in_if.v_elem <= '0;
    in_if.last   <= 1'b0;
    curv_r       = CURVATURE_RST;
    min_denom_r  = MIN_DENOM_RST;
    mode_r       = MODE_RST;
    norm_p       = '0;
    norm_q       = '0;
    scale_r      = SCALE_ONE;
    n_errors     = 0;
    n_loads      = 0;
    n_points     = 0;
    n_vectors    = 0;
    n_checked    = 0;
    n_sat_seen   = 0;
    n_settings   = 0;
    burst_left   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_vector_before_point();
    test_mode_scales();
    test_nonpositive_curvature();
    test_scale_saturation();
    test_unused_mode();
    test_random_traffic();
    drain();

    $display("covered %0d load items in %0d points and %0d vector items",
             n_loads, n_points, n_vectors);
    $display("checked %0d results (%0d clipped) over %0d phases of register settings",
             n_checked, n_sat_seen, n_settings);
    if (n_errors == 0 && transported_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors,
               transported_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
